### hdl/ihex_pkg.sv
// ---------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and helpers of the Intel HEX record encoder.
// ---------------------------------------------------------------------------
package ihex_pkg;

  // address space holds 2^ADDR_BITS bytes (16..20)
  localparam int ADDR_BITS = 20;

  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // one classified byte handed from front to back
  typedef struct packed {
    logic        seg_rec;   // segment record comes first
    logic        row_hdr;   // data record header before the digits
    logic        row_end;   // checksum and CR LF after the digits
    logic        eof_rec;   // end record closes the file
    logic [3:0]  seg_nib;   // segment bits 15..12
    logic [15:0] offset;
    logic [7:0]  data;
    logic [7:0]  row_sum;   // record sum including this byte
  } ihex_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ihex_qstat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CH_ZERO + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

### hdl/ihex_if.sv
// ---------------------------------------------------------------------------
// ihex_if
// Valid/ready channels of the encoder: byte input and character output.
// ---------------------------------------------------------------------------
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ihex_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       file_done;

  modport source (output valid, output text_char, output last_char, output file_done,
                  input ready);
  modport sink   (input valid, input text_char, input last_char, input file_done,
                  output ready);
endinterface

### hdl/ihex_front.sv
// ---------------------------------------------------------------------------
// ihex_front
// Tracks the byte address and record sum, classifies each byte into a job.
// ---------------------------------------------------------------------------
module ihex_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data,
  input  ihex_pkg::ihex_qstat_t q_stat,
  output logic                 push,
  output ihex_pkg::ihex_job_t  job
);

  logic [ihex_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  logic                           fin_r, fin_nxt;
  logic [7:0]                     base_sum;

  // bytes after the end record are taken and dropped
  assign in_ready = fin_r || !q_stat.full;
  assign push     = in_valid && in_ready && !fin_r;

  always_comb begin
    job.offset  = addr_r[15:0];
    job.seg_nib = 4'(addr_r >> 16);
    job.seg_rec = (addr_r[15:0] == 16'h0000);
    job.row_hdr = (addr_r[3:0] == 4'h0);
    job.row_end = (addr_r[3:0] == 4'hF);
    job.eof_rec = (addr_r == {ihex_pkg::ADDR_BITS{1'b1}});
    job.data    = in_data;
    base_sum    = job.row_hdr ? 8'(8'h10 + addr_r[15:8] + addr_r[7:0]) : sum_r;
    job.row_sum = 8'(base_sum + in_data);
  end

  always_comb begin
    addr_nxt = addr_r;
    sum_nxt  = sum_r;
    fin_nxt  = fin_r;
    if (push) begin
      addr_nxt = addr_r + 1'b1;
      sum_nxt  = job.row_sum;
      fin_nxt  = job.eof_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      sum_r  <= '0;
      fin_r  <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      sum_r  <= sum_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

### hdl/ihex_queue.sv
// ---------------------------------------------------------------------------
// ihex_queue
// Short job queue between the classifying front and the character back.
// ---------------------------------------------------------------------------
module ihex_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ihex_pkg::ihex_job_t   wr_job,
  input  logic                  pop,
  output ihex_pkg::ihex_job_t   head,
  output ihex_pkg::ihex_qstat_t stat
);

  ihex_pkg::ihex_job_t              slot_r [ihex_pkg::Q_DEPTH];
  logic [ihex_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ihex_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ihex_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == ihex_pkg::Q_CNT_W'(ihex_pkg::Q_DEPTH));
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ihex_pkg::Q_CNT_W'(ihex_pkg::Q_DEPTH))
    else $error("job queue count out of range");

endmodule

### hdl/ihex_back.sv
// ---------------------------------------------------------------------------
// ihex_back
// Walks the character layout of the head job into the output register,
// one character per cycle while a job waits and the output is not stalled.
// ---------------------------------------------------------------------------
module ihex_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ihex_pkg::ihex_job_t   head,
  input  ihex_pkg::ihex_qstat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_last,
  output logic                  out_done
);

  // layout of the characters one byte can cause
  localparam logic [5:0] P_SEG     = 6'd0;
  localparam logic [5:0] P_SEG_END = 6'd16;
  localparam logic [5:0] P_HDR     = 6'd17;
  localparam logic [5:0] P_DAT     = 6'd26;
  localparam logic [5:0] P_DAT_END = 6'd27;
  localparam logic [5:0] P_TRL     = 6'd28;
  localparam logic [5:0] P_TRL_END = 6'd31;
  localparam logic [5:0] P_EOF     = 6'd32;
  localparam logic [5:0] P_EOF_END = 6'd44;

  logic [5:0] pos_r, pos_nxt;
  logic       active_r, active_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] char_r;
  logic       last_r;
  logic       done_r;
  logic [5:0] cur_pos;
  logic       load;
  logic       job_end;
  logic [7:0] ch;
  logic [7:0] seg_ck;
  logic [7:0] row_ck;

  assign seg_ck = 8'(8'h00 - (8'h04 + {head.seg_nib, 4'h0}));
  assign row_ck = 8'(8'h00 - head.row_sum);

  always_comb begin
    if (active_r) begin
      cur_pos = pos_r;
    end else if (head.seg_rec) begin
      cur_pos = P_SEG;
    end else if (head.row_hdr) begin
      cur_pos = P_HDR;
    end else begin
      cur_pos = P_DAT;
    end
  end

  always_comb begin
    unique case (cur_pos) inside
      6'd0, 6'd17, 6'd32:                  ch = ihex_pkg::CH_COLON;
      6'd2, 6'd8:                          ch = ihex_pkg::CH_TWO;
      6'd1, [6'd3:6'd7], [6'd10:6'd12]:    ch = ihex_pkg::CH_ZERO;
      6'd9:                                ch = ihex_pkg::hex_digit(head.seg_nib);
      6'd13:                               ch = ihex_pkg::hex_digit(seg_ck[7:4]);
      6'd14:                               ch = ihex_pkg::hex_digit(seg_ck[3:0]);
      6'd15, 6'd30, 6'd43:                 ch = ihex_pkg::CH_CR;
      6'd16, 6'd31, 6'd44:                 ch = ihex_pkg::CH_LF;
      6'd18, 6'd40:                        ch = ihex_pkg::CH_ONE;
      6'd19, 6'd24, 6'd25, [6'd33:6'd39]:  ch = ihex_pkg::CH_ZERO;
      6'd20:                               ch = ihex_pkg::hex_digit(head.offset[15:12]);
      6'd21:                               ch = ihex_pkg::hex_digit(head.offset[11:8]);
      6'd22:                               ch = ihex_pkg::hex_digit(head.offset[7:4]);
      6'd23:                               ch = ihex_pkg::hex_digit(head.offset[3:0]);
      6'd26:                               ch = ihex_pkg::hex_digit(head.data[7:4]);
      6'd27:                               ch = ihex_pkg::hex_digit(head.data[3:0]);
      6'd28:                               ch = ihex_pkg::hex_digit(row_ck[7:4]);
      6'd29:                               ch = ihex_pkg::hex_digit(row_ck[3:0]);
      6'd41, 6'd42:                        ch = ihex_pkg::CH_F;
      default:                             ch = 8'h00;
    endcase
  end

  always_comb begin
    job_end = ((cur_pos == P_DAT_END) && !head.row_end && !head.eof_rec)
           || ((cur_pos == P_TRL_END) && !head.eof_rec)
           || (cur_pos == P_EOF_END);
    // skip the sections this byte does not need
    if (cur_pos == P_SEG_END) begin
      pos_nxt = head.row_hdr ? P_HDR : P_DAT;
    end else if (cur_pos == P_DAT_END) begin
      pos_nxt = head.row_end ? P_TRL : P_EOF;
    end else begin
      pos_nxt = cur_pos + 6'd1;
    end
  end

  assign load = !q_stat.empty && (!vld_r || out_ready);
  assign pop  = load && job_end;

  always_comb begin
    active_nxt = active_r;
    vld_nxt    = vld_r;
    if (load) begin
      active_nxt = !job_end;
      vld_nxt    = 1'b1;
    end else if (out_ready) begin
      vld_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_r  <= pos_nxt;
      char_r <= ch;
      last_r <= job_end;
      done_r <= job_end && (cur_pos == P_EOF_END);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      active_r <= active_nxt;
      vld_r    <= vld_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_char  = char_r;
  assign out_last  = last_r;
  assign out_done  = done_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && done_r) |-> last_r)
    else $error("end of file not on the last character of a byte");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_ready) |=> (vld_r && $stable(char_r)))
    else $error("stalled output word changed");

endmodule

### hdl/intel_hex_record_encoder_core.sv
// ---------------------------------------------------------------------------
// intel_hex_record_encoder_core
// Turns a byte stream from address 0 into Intel HEX text with segment
// records, 16-byte data records and an end record.
// ---------------------------------------------------------------------------
//  channel  dir  word                               handshake
//  in_ch    in   data_byte[7:0]                     valid/ready
//  out_ch   out  text_char[7:0] last_char file_done valid/ready
//
//  one output character per cycle from the output register while out_ch is
//  ready and a job waits; a byte causes 2 to 28 characters (45 characters
//  per 16-byte row), so the single character port sets the sustained rate.
//  a 4-deep job queue lets the input take bytes while characters drain.
//  rst_n is synchronous; bytes after the end record are taken and dropped.
// ---------------------------------------------------------------------------
module intel_hex_record_encoder_core (
  input  logic              clk,
  input  logic              rst_n,
  ihex_in_if.sink           in_ch,
  ihex_out_if.source        out_ch
);

  ihex_pkg::ihex_job_t   wr_job;
  ihex_pkg::ihex_job_t   head;
  ihex_pkg::ihex_qstat_t q_stat;
  logic                  push;
  logic                  pop;

  ihex_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data_byte),
    .q_stat   (q_stat),
    .push     (push),
    .job      (wr_job)
  );

  ihex_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .stat   (q_stat)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.text_char),
    .out_last  (out_ch.last_char),
    .out_done  (out_ch.file_done)
  );

endmodule

### test/ihex_char_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ihex_char_checker
// Watches both channels of the encoder, predicts the hex text of every byte
// taken and compares each character word with the oldest prediction.
// ---------------------------------------------------------------------------
module ihex_char_checker (
  input  logic clk,
  input  logic rst_n,
  ihex_in_if   in_mon,
  ihex_out_if  out_mon,
  output int   fail_count,
  output int   pending_chars
);

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic       file_done;
  } hex_char_t;

  localparam logic [20:0] SPACE_MASK = 21'((64'd1 << ihex_pkg::ADDR_BITS) - 64'd1);

  hex_char_t   char_q[$];
  logic [20:0] next_addr;
  logic [7:0]  row_sum;
  logic        space_done;
  int          mismatches = 0;
  int          queued_n = 0;

  assign fail_count    = mismatches;
  assign pending_chars = queued_n;

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    // digits, then uppercase letters from 'A'
    return (n < 4'd10) ? ihex_pkg::CH_ZERO + 8'(n) : 8'h41 + 8'(n) - 8'd10;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    hex_char_t w;
    w.text_char = c;
    w.last_char = 1'b0;
    w.file_done = 1'b0;
    char_q.push_back(w);
  endfunction

  function automatic void put_hex8(input logic [7:0] v);
    put_char(nibble_char(v[7:4]));
    put_char(nibble_char(v[3:0]));
  endfunction

  function automatic void put_hex16(input logic [15:0] v);
    put_hex8(v[15:8]);
    put_hex8(v[7:0]);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i]);
    end
  endfunction

  function automatic void put_crlf();
    put_char(ihex_pkg::CH_CR);
    put_char(ihex_pkg::CH_LF);
  endfunction

  // text caused by one byte, appended to the character queue
  function automatic void encode_byte(input logic [7:0] d);
    logic [20:0] a;
    logic [15:0] off;
    logic [15:0] seg;
    logic [7:0]  s;
    if (space_done) begin
      return;
    end
    a   = next_addr & SPACE_MASK;
    off = a[15:0];
    if (off == 16'h0000) begin
      seg = 16'((a >> 16) << 12);
      s   = 8'h04 + seg[15:8] + seg[7:0];
      put_str(":02000002");
      put_hex16(seg);
      put_hex8(8'h00 - s);
      put_crlf();
    end
    if (a[3:0] == 4'h0) begin
      put_str(":10");
      put_hex16(off);
      put_str("00");
      row_sum = 8'h10 + off[15:8] + off[7:0];
    end
    put_hex8(d);
    row_sum = row_sum + d;
    if (a[3:0] == 4'hF) begin
      put_hex8(8'h00 - row_sum);
      put_crlf();
    end
    if (a == SPACE_MASK) begin
      put_str(":00000001FF");
      put_crlf();
      space_done = 1'b1;
      char_q[char_q.size() - 1].file_done = 1'b1;
    end
    char_q[char_q.size() - 1].last_char = 1'b1;
    next_addr = a + 21'd1;
  endfunction

  always @(posedge clk) begin
    hex_char_t want;
    if (!rst_n) begin
      next_addr  = '0;
      row_sum    = '0;
      space_done = 1'b0;
      char_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        encode_byte(in_mon.data_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected character word, expected none, got %h", $time,
                   out_mon.text_char);
          mismatches++;
        end else begin
          want = char_q.pop_front();
          if (out_mon.text_char !== want.text_char) begin
            $display("%0t: text_char expected %h got %h", $time, want.text_char,
                     out_mon.text_char);
            mismatches++;
          end
          if (out_mon.last_char !== want.last_char) begin
            $display("%0t: last_char expected %b got %b", $time, want.last_char,
                     out_mon.last_char);
            mismatches++;
          end
          if (out_mon.file_done !== want.file_done) begin
            $display("%0t: file_done expected %b got %b", $time, want.file_done,
                     out_mon.file_done);
            mismatches++;
          end
        end
      end
    end
    queued_n <= char_q.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Feeds the Intel HEX encoder about 460 bytes from address 0: directed
// values first, then random bursts under receiver stalls, a fast stretch
// with the receiver always ready, and a stalled tail. A checker beside the
// block predicts and compares every character.
// ---------------------------------------------------------------------------
module testbench;

  localparam int TOTAL_BYTES = 460;

  logic clk;
  logic rst_n;
  logic rx_ready = 1'b1;
  bit   stall_on = 1'b1;
  int   stall_left = 0;
  int   sent_bytes = 0;
  int   fail_count;
  int   pending_chars;

  ihex_in_if  in_ch ();
  ihex_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  intel_hex_record_encoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ihex_char_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_chars (pending_chars)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL intel_hex_record_encoder_core");
    $finish;
  end

  // receiver: alternating ready and stall stretches, mostly short ones
  always @(posedge clk) begin
    if (!stall_on) begin
      rx_ready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      if (rx_ready) begin
        rx_ready   <= 1'b0;
        stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(1, 4);
      end else begin
        rx_ready   <= 1'b1;
        stall_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic push_word(input logic [7:0] value);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
  endtask

  // random bytes, optionally in bursts with gaps between them
  task automatic send_run(input int count, input bit with_gaps);
    int burst;
    int gap;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      push_word(8'($urandom_range(0, 255)));
      burst--;
      if (burst == 0) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
        if (with_gaps) begin
          case ($urandom_range(0, 5))
            0:       gap = 0;
            1:       gap = $urandom_range(10, 40);
            default: gap = $urandom_range(1, 4);
          endcase
          if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end
  endtask

  initial begin
    logic [7:0] first_words[25];
    first_words = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h0F, 8'hF0, 8'h09,
                    8'h0A, 8'h90, 8'hA0, 8'h5A, 8'hA5, 8'h99, 8'hAA, 8'hFE,
                    8'hFF, 8'hFF, 8'h00, 8'h00, 8'hC3, 8'h3C, 8'h19, 8'hE6, 8'h55};
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first row and a bit of the second, digits at both ends of the range
    foreach (first_words[i]) begin
      push_word(first_words[i]);
    end
    wait_drained();

    send_run(230, 1'b1);
    wait_drained();

    // fast stretch with the receiver always ready
    stall_on <= 1'b0;
    send_run(100, 1'b0);

    // stalled tail
    stall_on <= 1'b1;
    send_run(TOTAL_BYTES - sent_bytes, 1'b1);

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("PASS intel_hex_record_encoder_core");
    end else begin
      $display("FAIL intel_hex_record_encoder_core");
    end
    $finish;
  end

endmodule
